### rtl/core/ilp_pkg.sv
// Shared types, state codes and constants for the integer literal parser.
`default_nettype none

package ilp_pkg;

    // Parser phase codes
    localparam logic [2:0] PH_START = 3'd0;
    localparam logic [2:0] PH_DEC   = 3'd1;
    localparam logic [2:0] PH_SDEC  = 3'd2;
    localparam logic [2:0] PH_ZERO  = 3'd3;
    localparam logic [2:0] PH_BIN   = 3'd4;
    localparam logic [2:0] PH_HEX   = 3'd5;

    // Configuration register indexes
    localparam logic CFG_BIN_MAX = 1'b0;
    localparam logic CFG_HEX_MAX = 1'b1;

    localparam logic [5:0] BIN_MAX_RESET = 6'd32;
    localparam logic [3:0] HEX_MAX_RESET = 4'd8;

    // Overflow guards and caps
    localparam logic [31:0] DEC_GUARD = 32'd214748364;
    localparam logic [30:0] BIN_GUARD = 31'd1073741823;
    localparam logic [30:0] HEX_GUARD = 31'd134217727;
    localparam logic [5:0]  COUNT_MAX = 6'd63;
    localparam logic [5:0]  BIN_CAP   = 6'd32;
    localparam logic [5:0]  HEX_CAP   = 6'd8;

    // Characters
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_1     = 8'h31;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UB    = 8'h42;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LB    = 8'h62;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_LX    = 8'h78;

    typedef struct packed {
        logic       is_dec;
        logic       is_bin;
        logic       is_hex;
        logic       is_sign;
        logic       is_minus;
        logic       is_zero;
        logic       is_nonzero;
        logic       is_b;
        logic       is_x;
        logic [3:0] digit;
    } char_class_t;

    typedef struct packed {
        logic [2:0]  phase;
        logic [30:0] acc;
        logic [5:0]  count;
        logic        negative;
    } parse_state_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] value;
        logic [5:0]  length;
        logic [7:0]  stop_char;
        logic        stopped_at_end;
    } parse_result_t;

    localparam parse_state_t START_STATE = '{PH_START, 31'd0, 6'd0, 1'b0};

endpackage

`default_nettype wire

### rtl/core/ilp_char_class.sv
// Character classifier: digit, sign and prefix-letter classes and hex digit value of one byte.
`default_nettype none

module ilp_char_class (
    input  wire logic [7:0]          ch,
    output ilp_pkg::char_class_t     cls
);
    import ilp_pkg::*;

    logic upper_hex;
    logic lower_hex;

    always_comb begin
        cls            = '0;
        cls.is_dec     = (ch >= CH_0) && (ch <= CH_9);
        cls.is_bin     = (ch == CH_0) || (ch == CH_1);
        upper_hex      = (ch >= CH_UA) && (ch <= CH_UF);
        lower_hex      = (ch >= CH_LA) && (ch <= CH_LF);
        cls.is_hex     = cls.is_dec || upper_hex || lower_hex;
        cls.is_sign    = (ch == CH_PLUS) || (ch == CH_MINUS);
        cls.is_minus   = (ch == CH_MINUS);
        cls.is_zero    = (ch == CH_0);
        cls.is_nonzero = (ch >= CH_1) && (ch <= CH_9);
        cls.is_b       = (ch == CH_LB) || (ch == CH_UB);
        cls.is_x       = (ch == CH_LX) || (ch == CH_UX);
        if (upper_hex) begin
            cls.digit = 4'(ch - CH_UA + 8'd10);
        end else if (lower_hex) begin
            cls.digit = 4'(ch - CH_LA + 8'd10);
        end else begin
            cls.digit = ch[3:0];
        end
    end

endmodule

`default_nettype wire

### rtl/core/ilp_step.sv
// Next-state and result logic for one character of the literal.
`default_nettype none

module ilp_step (
    input  wire ilp_pkg::parse_state_t  cur,
    input  wire ilp_pkg::char_class_t   cls,
    input  wire logic [7:0]             ch,
    input  wire logic                   at_end,
    input  wire logic [5:0]             bin_max,
    input  wire logic [3:0]             hex_max,
    output ilp_pkg::parse_state_t       nxt,
    output ilp_pkg::parse_result_t      res
);
    import ilp_pkg::*;

    logic [31:0] dec_sum;
    logic [30:0] dec_acc;
    logic [5:0]  count_inc;
    logic [5:0]  dec_len;
    logic [31:0] acc_wide;
    logic [31:0] dec_value;

    function automatic parse_result_t emit(input logic [31:0] val, input logic [5:0] len,
                                           input logic [7:0] c, input logic e);
        parse_result_t r;
        r.valid          = 1'b1;
        r.value          = (len == 6'd0) ? 32'd0 : val;
        r.length         = len;
        r.stop_char      = e ? 8'd0 : c;
        r.stopped_at_end = e;
        return r;
    endfunction

    always_comb begin
        acc_wide  = {1'b0, cur.acc};
        // Guard acc < G and d < G - acc folds into a single sum compare.
        dec_sum   = acc_wide + {28'd0, cls.digit};
        dec_acc   = 31'({cur.acc[27:0], 3'b000} + {cur.acc[29:0], 1'b0}
                        + {27'd0, cls.digit});
        count_inc = (cur.count == COUNT_MAX) ? COUNT_MAX : cur.count + 6'd1;
        dec_len   = (cur.phase == PH_SDEC && cur.count < COUNT_MAX) ? cur.count + 6'd1
                                                                    : cur.count;
        dec_value = cur.negative ? (32'd0 - acc_wide) : acc_wide;

        nxt = cur;
        res = '0;

        unique case (cur.phase)
            PH_DEC, PH_SDEC: begin
                if (!at_end && cls.is_dec) begin
                    if (dec_sum < DEC_GUARD) begin
                        nxt.acc   = dec_acc;
                        nxt.count = count_inc;
                    end else begin
                        res = emit(32'd0, 6'd0, ch, at_end);
                        nxt = START_STATE;
                    end
                end else begin
                    if (cur.count == 6'd0) begin
                        res = emit(32'd0, 6'd0, ch, at_end);
                    end else begin
                        res = emit(dec_value, dec_len, ch, at_end);
                    end
                    nxt = START_STATE;
                end
            end
            PH_ZERO: begin
                if (!at_end && cls.is_b) begin
                    nxt.phase = PH_BIN;
                end else if (!at_end && cls.is_x) begin
                    nxt.phase = PH_HEX;
                end else begin
                    res = emit(32'd0, 6'd1, ch, at_end);
                    nxt = START_STATE;
                end
            end
            PH_BIN: begin
                nxt = START_STATE;
                if (at_end) begin
                    res = emit(acc_wide, cur.count, ch, at_end);
                end else if (cur.count >= bin_max || cur.count > BIN_CAP) begin
                    res = emit(32'd0, 6'd0, ch, at_end);
                end else if (cls.is_bin) begin
                    if (cur.acc > BIN_GUARD) begin
                        res = emit(32'd0, 6'd0, ch, at_end);
                    end else begin
                        nxt       = cur;
                        nxt.acc   = {cur.acc[29:0], cls.digit[0]};
                        nxt.count = count_inc;
                    end
                end else begin
                    res = emit(acc_wide, cur.count, ch, at_end);
                end
            end
            PH_HEX: begin
                nxt = START_STATE;
                if (at_end) begin
                    res = emit(acc_wide, cur.count, ch, at_end);
                end else if (cur.count >= {2'b00, hex_max} || cur.count > HEX_CAP) begin
                    res = emit(32'd0, 6'd0, ch, at_end);
                end else if (cls.is_hex) begin
                    if (cur.acc > HEX_GUARD) begin
                        res = emit(32'd0, 6'd0, ch, at_end);
                    end else begin
                        nxt       = cur;
                        nxt.acc   = {cur.acc[26:0], cls.digit};
                        nxt.count = count_inc;
                    end
                end else begin
                    res = emit(acc_wide, cur.count, ch, at_end);
                end
            end
            default: begin
                // Start phase, and any stray code behaves as start.
                nxt = START_STATE;
                if (at_end) begin
                    res = emit(32'd0, 6'd0, ch, at_end);
                end else if (cls.is_sign) begin
                    nxt.phase    = PH_SDEC;
                    nxt.negative = cls.is_minus;
                end else if (cls.is_zero) begin
                    nxt.phase = PH_ZERO;
                end else if (cls.is_nonzero) begin
                    nxt.phase = PH_DEC;
                    nxt.acc   = {27'd0, cls.digit};
                    nxt.count = 6'd1;
                end else begin
                    res = emit(32'd0, 6'd0, ch, at_end);
                end
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/core/ilp_result_reg.sv
// Output register holding one result request until the receiver takes it.
`default_nettype none

module ilp_result_reg (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    load,
    input  wire ilp_pkg::parse_result_t  res,
    output logic                         slot_free,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output logic signed [31:0]           m_value,
    output logic [5:0]                   m_length,
    output logic [7:0]                   m_stop_char,
    output logic                         m_stopped_at_end
);
    import ilp_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    logic [31:0] value_reg;
    logic [5:0]  length_reg;
    logic [7:0]  stop_char_reg;
    logic        stopped_at_end_reg;

    // The slot frees in the same cycle that the held request is taken.
    assign slot_free = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            value_reg          <= res.value;
            length_reg         <= res.length;
            stop_char_reg      <= res.stop_char;
            stopped_at_end_reg <= res.stopped_at_end;
        end
    end

    assign m_valid          = valid_reg;
    assign m_value          = value_reg;
    assign m_length         = length_reg;
    assign m_stop_char      = stop_char_reg;
    assign m_stopped_at_end = stopped_at_end_reg;

endmodule

`default_nettype wire

### rtl/core/integer_literal_parser_core.sv
// Top level of the streaming integer literal parser.
//
// Characters enter one per request on the s_ channel (s_ch, with s_at_end
// marking end of stream). A literal is decimal with optional sign, a lone
// zero, 0b/0B binary or 0x/0X hex. When a character that cannot continue
// the literal arrives, or end of stream, one result request appears on
// the m_ channel in the cycle after that character is accepted; the stop
// character itself is returned in m_stop_char and consumed; it starts no
// new literal. Every other character produces no result. Throughput is one
// character per cycle: the parser state and the result are registered, so
// s_ready stays high while the output register is empty or being drained.
// If the receiver holds m_ready low with a result pending, s_ready drops
// until it is taken. Reset returns the parser to its start state, empties
// the output register and sets the digit limits to 32 binary and 8 hex
// digits. The limits are written through cfg_we/cfg_index/cfg_wdata only
// while no literal is in flight, a user rule the block does not enforce.
`default_nettype none

module integer_literal_parser_core (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_we,
    input  wire logic                cfg_index,
    input  wire logic [5:0]          cfg_wdata,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [7:0]          s_ch,
    input  wire logic                s_at_end,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic signed [31:0]       m_value,
    output logic [5:0]               m_length,
    output logic [7:0]               m_stop_char,
    output logic                     m_stopped_at_end
);
    import ilp_pkg::*;

    logic [5:0]    bin_max_reg;
    logic [3:0]    hex_max_reg;
    parse_state_t  state_reg;
    parse_state_t  state_next;
    char_class_t   cls;
    parse_result_t res;
    logic          accept;

    assign accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bin_max_reg <= BIN_MAX_RESET;
            hex_max_reg <= HEX_MAX_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_BIN_MAX: bin_max_reg <= cfg_wdata;
                CFG_HEX_MAX: hex_max_reg <= cfg_wdata[3:0];
                default:     bin_max_reg <= bin_max_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= START_STATE;
        end else if (accept) begin
            state_reg <= state_next;
        end
    end

    ilp_char_class u_class (
        .ch  (s_ch),
        .cls (cls)
    );

    ilp_step u_step (
        .cur     (state_reg),
        .cls     (cls),
        .ch      (s_ch),
        .at_end  (s_at_end),
        .bin_max (bin_max_reg),
        .hex_max (hex_max_reg),
        .nxt     (state_next),
        .res     (res)
    );

    ilp_result_reg u_out (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .load             (accept && res.valid),
        .res              (res),
        .slot_free        (s_ready),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_value          (m_value),
        .m_length         (m_length),
        .m_stop_char      (m_stop_char),
        .m_stopped_at_end (m_stopped_at_end)
    );

`ifndef ASSERT_OFF
    // A failed literal always reports a zero value.
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_length == 6'd0) |-> (m_value == 32'd0))
        else $error("failure result with non-zero value");

    // End of stream never reports a stop character.
    a_end_char: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_stopped_at_end |-> (m_stop_char == 8'd0))
        else $error("stop character reported at end of stream");

    // Emitting a result returns the parser to a clean start state.
    a_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && res.valid |=> (state_reg == START_STATE))
        else $error("parser not restarted after a result");

    // End of stream always produces a result.
    a_end_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_at_end |=> m_valid && m_stopped_at_end)
        else $error("end of stream gave no result");

    // Input is only held off by a pending result.
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with empty output register");
`endif

endmodule

`default_nettype wire

### sim/integer_literal_parser_core_tb.sv
// Self-checking testbench for the streaming integer literal parser core.
`default_nettype none

module integer_literal_parser_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ilp_pkg::*;

    localparam int HOLD_AT       = 25;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 4;
    localparam int NUM_PHASES    = 6;

    typedef struct packed {
        logic [7:0] ch;
        logic       at_end;
    } char_req_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic [5:0]         length;
        logic [7:0]         stop_char;
        logic               stopped_at_end;
    } literal_t;

    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               cfg_we    = 1'b0;
    logic               cfg_index = 1'b0;
    logic [5:0]         cfg_wdata = '0;
    logic               s_valid   = 1'b0;
    logic               s_ready;
    logic [7:0]         s_ch      = '0;
    logic               s_at_end  = 1'b0;
    logic               m_valid;
    logic               m_ready   = 1'b0;
    logic signed [31:0] m_value;
    logic [5:0]         m_length;
    logic [7:0]         m_stop_char;
    logic               m_stopped_at_end;

    char_req_t pending_chars[$];
    literal_t  expected_literals[$];
    int        chars_queued = 0;
    int        results_seen = 0;
    int        mismatches   = 0;
    bit        idle_on      = 1'b1;
    int        send_gap     = 0;
    int        stall_left   = 0;
    int        hold_left    = 0;
    bit        hold_done    = 1'b0;

    // Predicted parser state and digit limits.
    logic [2:0]  lp_phase  = PH_START;
    logic [31:0] lp_acc    = '0;
    logic [5:0]  lp_count  = '0;
    logic        lp_neg    = 1'b0;
    logic [5:0]  bin_limit = BIN_MAX_RESET;
    logic [3:0]  hex_limit = HEX_MAX_RESET;

    integer_literal_parser_core uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_ch             (s_ch),
        .s_at_end         (s_at_end),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_value          (m_value),
        .m_length         (m_length),
        .m_stop_char      (m_stop_char),
        .m_stopped_at_end (m_stopped_at_end)
    );

    always #5 aclk = ~aclk;

    function automatic literal_t finish_literal(input logic [31:0] v, input logic [5:0] len,
                                                input logic [7:0] c, input logic at_end);
        literal_t r;
        r.value          = (len == '0) ? '0 : v;
        r.length         = len;
        r.stop_char      = at_end ? 8'h00 : c;
        r.stopped_at_end = at_end;
        lp_phase = PH_START;
        lp_acc   = '0;
        lp_count = '0;
        lp_neg   = 1'b0;
        return r;
    endfunction

    // Advances the predicted parser by one character; returns 1 when a literal completes.
    function automatic bit parse_char(input logic [7:0] c, input logic at_end,
                                      output literal_t r);
        logic [31:0] dv;
        logic [5:0]  len;
        int          hv;
        r = '0;
        case (lp_phase)
            PH_DEC, PH_SDEC: begin
                if (!at_end && c >= CH_0 && c <= CH_9) begin
                    dv = 32'(c - CH_0);
                    if (lp_acc < DEC_GUARD && dv < DEC_GUARD - lp_acc) begin
                        lp_acc = lp_acc * 32'd10 + dv;
                        if (lp_count < COUNT_MAX) lp_count++;
                        return 1'b0;
                    end
                    r = finish_literal('0, '0, c, at_end);
                    return 1'b1;
                end
                if (lp_count == '0) begin
                    r = finish_literal('0, '0, c, at_end);
                    return 1'b1;
                end
                len = lp_count;
                if (lp_phase == PH_SDEC && len < COUNT_MAX) len++;
                r = finish_literal(lp_neg ? (32'd0 - lp_acc) : lp_acc, len, c, at_end);
                return 1'b1;
            end
            PH_ZERO: begin
                if (!at_end && (c == CH_LB || c == CH_UB)) begin
                    lp_phase = PH_BIN;
                    return 1'b0;
                end
                if (!at_end && (c == CH_LX || c == CH_UX)) begin
                    lp_phase = PH_HEX;
                    return 1'b0;
                end
                r = finish_literal('0, 6'd1, c, at_end);
                return 1'b1;
            end
            PH_BIN: begin
                if (at_end) begin
                    r = finish_literal(lp_acc, lp_count, c, at_end);
                    return 1'b1;
                end
                if (lp_count >= bin_limit || lp_count > BIN_CAP) begin
                    r = finish_literal('0, '0, c, at_end);
                    return 1'b1;
                end
                if (c == CH_0 || c == CH_1) begin
                    if (lp_acc > BIN_GUARD) begin
                        r = finish_literal('0, '0, c, at_end);
                        return 1'b1;
                    end
                    lp_acc = {lp_acc[30:0], c[0]};
                    if (lp_count < COUNT_MAX) lp_count++;
                    return 1'b0;
                end
                r = finish_literal(lp_acc, lp_count, c, at_end);
                return 1'b1;
            end
            PH_HEX: begin
                if (at_end) begin
                    r = finish_literal(lp_acc, lp_count, c, at_end);
                    return 1'b1;
                end
                if (lp_count >= 6'(hex_limit) || lp_count > HEX_CAP) begin
                    r = finish_literal('0, '0, c, at_end);
                    return 1'b1;
                end
                if (c >= CH_0 && c <= CH_9) hv = int'(c - CH_0);
                else if (c >= CH_UA && c <= CH_UF) hv = int'(c - CH_UA) + 10;
                else if (c >= CH_LA && c <= CH_LF) hv = int'(c - CH_LA) + 10;
                else hv = -1;
                if (hv >= 0) begin
                    if (lp_acc > HEX_GUARD) begin
                        r = finish_literal('0, '0, c, at_end);
                        return 1'b1;
                    end
                    lp_acc = {lp_acc[27:0], 4'(hv)};
                    if (lp_count < COUNT_MAX) lp_count++;
                    return 1'b0;
                end
                r = finish_literal(lp_acc, lp_count, c, at_end);
                return 1'b1;
            end
            default: begin
                lp_phase = PH_START;
                lp_acc   = '0;
                lp_count = '0;
                lp_neg   = 1'b0;
                if (at_end) begin
                    r = finish_literal('0, '0, c, at_end);
                    return 1'b1;
                end
                if (c == CH_PLUS || c == CH_MINUS) begin
                    lp_neg   = (c == CH_MINUS);
                    lp_phase = PH_SDEC;
                    return 1'b0;
                end
                if (c == CH_0) begin
                    lp_phase = PH_ZERO;
                    return 1'b0;
                end
                if (c >= CH_1 && c <= CH_9) begin
                    lp_acc   = 32'(c - CH_0);
                    lp_count = 6'd1;
                    lp_phase = PH_DEC;
                    return 1'b0;
                end
                r = finish_literal('0, '0, c, at_end);
                return 1'b1;
            end
        endcase
    endfunction

    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(12, 40);
    endfunction

    function automatic void add_char(input logic [7:0] c, input logic at_end);
        pending_chars.push_back('{ch: c, at_end: at_end});
        chars_queued++;
    endfunction

    task automatic write_limit(input logic idx, input logic [5:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        if (idx == CFG_BIN_MAX) bin_limit = val;
        else hex_limit = val[3:0];
    endtask

    // Waits until every queued character has gone in and every literal has come out.
    task automatic settle();
        do @(posedge aclk);
        while (pending_chars.size() != 0 || s_valid || expected_literals.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    always @(posedge aclk) begin : char_driver
        char_req_t nxt;
        literal_t  res;
        bit        done;
        if (!aresetn) begin
            s_valid  <= 1'b0;
            s_ch     <= '0;
            s_at_end <= 1'b0;
            lp_phase = PH_START;
            lp_acc   = '0;
            lp_count = '0;
            lp_neg   = 1'b0;
            send_gap = 0;
        end else begin
            if (s_valid && s_ready) begin
                done = parse_char(s_ch, s_at_end, res);
                if (done) expected_literals.push_back(res);
                send_gap = idle_on ? idle_length() : 0;
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (pending_chars.size() != 0) begin
                    nxt = pending_chars.pop_front();
                    s_ch     <= nxt.ch;
                    s_at_end <= nxt.at_end;
                    s_valid  <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : literal_monitor
        literal_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_literals.size() == 0) begin
                    $error("literal result with none expected: value %0d, length %0d",
                           m_value, m_length);
                    mismatches++;
                end else begin
                    want = expected_literals.pop_front();
                    if (m_value !== want.value) begin
                        $error("value: expected %0d, got %0d", want.value, m_value);
                        mismatches++;
                    end
                    if (m_length !== want.length) begin
                        $error("length: expected %0d, got %0d", want.length, m_length);
                        mismatches++;
                    end
                    if (m_stop_char !== want.stop_char) begin
                        $error("stop_char: expected %02h, got %02h", want.stop_char, m_stop_char);
                        mismatches++;
                    end
                    if (m_stopped_at_end !== want.stopped_at_end) begin
                        $error("stopped_at_end: expected %0b, got %0b",
                               want.stopped_at_end, m_stopped_at_end);
                        mismatches++;
                    end
                end
            end
            // One long hold-off lets the output register fill and back-pressure the sender.
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (results_seen == HOLD_AT && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                stall_left = idle_on ? idle_length() : 0;
                m_ready <= (stall_left == 0);
                if (stall_left > 0) stall_left--;
            end
        end
    end

    initial begin
        #10_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    initial begin : stimulus
        logic [5:0]  bin_sets[NUM_PHASES];
        logic [5:0]  hex_sets[NUM_PHASES];
        int          phase_items[NUM_PHASES];
        int          ph, kind, n, zeros, t, d, i, start;
        logic [31:0] v;
        string       digits;
        string       stops;

        bin_sets    = '{6'd32, 6'd1, 6'd63, 6'd0, 6'($urandom_range(2, 31)), 6'd33};
        hex_sets    = '{6'd8, 6'd1, 6'd15, 6'd0, 6'($urandom_range(2, 7)), 6'd9};
        phase_items = '{250, 100, 120, 80, 130, 120};
        stops       = ",; )gZ";

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part, run with the limits left at their reset values.
        add_char(8'h00, 1'b1);
        add_char(8'hFF, 1'b0);
        add_char(8'h00, 1'b0);
        add_char(CH_MINUS, 1'b0);
        add_char(",", 1'b0);
        add_char(CH_0, 1'b0);
        add_char(" ", 1'b0);
        add_char(CH_0, 1'b0);
        add_char(8'h7F, 1'b1);
        add_char(CH_0, 1'b0);
        add_char(CH_LX, 1'b0);
        add_char("g", 1'b0);
        add_char(CH_0, 1'b0);
        add_char(CH_UB, 1'b0);
        add_char(CH_1, 1'b0);
        add_char(CH_0, 1'b0);
        add_char(CH_1, 1'b0);
        add_char(8'h55, 1'b1);
        add_char(CH_0, 1'b0);
        add_char(CH_UX, 1'b0);
        add_char(CH_LF, 1'b0);
        add_char(CH_UF, 1'b0);
        add_char(";", 1'b0);
        add_char(CH_PLUS, 1'b0);
        add_char(CH_9, 1'b0);
        add_char(" ", 1'b0);
        settle();

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            write_limit(CFG_BIN_MAX, bin_sets[ph]);
            write_limit(CFG_HEX_MAX, hex_sets[ph]);
            idle_on = (ph != 2);
            start = chars_queued;
            while (chars_queued - start < phase_items[ph]) begin
                kind = $urandom_range(0, 99);
                if (kind < 28) begin
                    t = $urandom_range(0, 2);
                    if (t == 1) add_char(CH_PLUS, 1'b0);
                    else if (t == 2) add_char(CH_MINUS, 1'b0);
                    case ($urandom_range(0, 3))
                        0: v = $urandom_range(0, 9999);
                        1: v = $urandom_range(32'd2147483500, 32'd2147483647);
                        2: v = $urandom;
                        default: v = $urandom_range(1, 999999999);
                    endcase
                    digits = $sformatf("%0d", v);
                    for (i = 0; i < digits.len(); i++) add_char(digits[i], 1'b0);
                end else if (kind < 30) begin
                    // Long runs of leading zeros after the sign, which can saturate the length field.
                    add_char($urandom_range(0, 1) ? CH_PLUS : CH_MINUS, 1'b0);
                    n = $urandom_range(58, 70);
                    for (i = 0; i < n; i++) add_char(CH_0, 1'b0);
                    n = $urandom_range(1, 3);
                    for (i = 0; i < n; i++) add_char(8'(CH_0 + $urandom_range(0, 9)), 1'b0);
                end else if (kind < 52) begin
                    add_char(CH_0, 1'b0);
                    add_char($urandom_range(0, 1) ? CH_LB : CH_UB, 1'b0);
                    n = $urandom_range(0, 1) ? $urandom_range(0, 8) : $urandom_range(25, 35);
                    zeros = ($urandom_range(0, 3) == 0) ? $urandom_range(0, n) : 0;
                    for (i = 0; i < n; i++)
                        add_char((i < zeros) ? CH_0 : 8'(CH_0 + $urandom_range(0, 1)), 1'b0);
                end else if (kind < 74) begin
                    add_char(CH_0, 1'b0);
                    add_char($urandom_range(0, 1) ? CH_LX : CH_UX, 1'b0);
                    n = $urandom_range(0, 11);
                    zeros = ($urandom_range(0, 3) == 0) ? $urandom_range(0, n) : 0;
                    for (i = 0; i < n; i++) begin
                        d = (i < zeros) ? 0 : $urandom_range(0, 15);
                        if (d < 10) add_char(8'(CH_0 + d), 1'b0);
                        else add_char(8'(($urandom_range(0, 1) ? CH_UA : CH_LA) + d - 10), 1'b0);
                    end
                end else if (kind < 82) begin
                    add_char(CH_0, 1'b0);
                end else if (kind < 90) begin
                    add_char($urandom_range(0, 1) ? CH_PLUS : CH_MINUS, 1'b0);
                end else begin
                    n = $urandom_range(1, 3);
                    for (i = 0; i < n; i++) add_char(8'($urandom_range(0, 255)), 1'b0);
                end
                t = $urandom_range(0, 9);
                if (t < 3) add_char(8'($urandom_range(0, 255)), 1'b1);
                else if (t < 6) add_char(8'($urandom_range(0, 255)), 1'b0);
                else add_char(stops[$urandom_range(0, stops.len() - 1)], 1'b0);
            end
            // End of stream returns the parser to its start state before the next write.
            add_char(8'($urandom_range(0, 255)), 1'b1);
            settle();
        end

        if (mismatches == 0 && expected_literals.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

`default_nettype wire
